// ===== src/hermite_table_interpolator_macros.svh =====
// Assertion macros used by the interpolator RTL.
`ifndef HERMITE_TABLE_INTERPOLATOR_MACROS_SVH
`define HERMITE_TABLE_INTERPOLATOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// Implication within the same cycle.
`define HTI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hti assertion failed");

// Implication in the next cycle.
`define HTI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hti assertion failed");

`else

`define HTI_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define HTI_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/hti_pkg.sv =====
`default_nettype none

package hti_pkg;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_NO_KNOTS   = 2'd1;
    localparam logic [1:0] STATUS_ZERO_WIDTH = 2'd2;

    typedef struct packed {
        logic signed [31:0] pos;
        logic signed [31:0] val;
        logic signed [31:0] slope;
    } knot_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH_ADDR,
        ST_SRCH_CMP,
        ST_PAIR_LO,
        ST_PAIR_HI,
        ST_PAIR_END,
        ST_PREP,
        ST_MUL_ISSUE,
        ST_MUL_WB,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_FINISH,
        ST_ONE_ADDR,
        ST_ONE_LATCH,
        ST_RESULT
    } state_t;

    typedef enum logic [3:0] {
        STEP_U,
        STEP_U2,
        STEP_U3,
        STEP_YB2,
        STEP_YB4,
        STEP_T,
        STEP_VA,
        STEP_VB,
        STEP_VC,
        STEP_Q1,
        STEP_Q2,
        STEP_SA,
        STEP_SB
    } step_t;

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > 40'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -40'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/hti_knot_mem.sv =====
`default_nettype none

module hti_knot_mem #(
    parameter int MAX_KNOTS = 64,
    parameter int AW        = 6
) (
    input  wire logic           aclk,
    input  wire logic           we,
    input  wire logic [AW-1:0]  waddr,
    input  wire hti_pkg::knot_t wdata,
    input  wire logic [AW-1:0]  raddr,
    output hti_pkg::knot_t      rdata
);

    hti_pkg::knot_t mem [MAX_KNOTS];
    hti_pkg::knot_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== src/hti_fxmul.sv =====
`default_nettype none

module hti_fxmul #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               aclk,
    input  wire logic               load,
    input  wire logic signed [31:0] a,
    input  wire logic signed [31:0] b,
    output logic signed [31:0]      res
);

    logic signed [63:0] prod_reg;
    logic signed [63:0] shifted;

    always_ff @(posedge aclk) begin
        if (load) begin
            prod_reg <= 64'(a) * 64'(b);
        end
    end

    // The arithmetic shift rounds toward minus infinity.
    assign shifted = prod_reg >>> FRAC_BITS;

    always_comb begin
        if (shifted > 64'sd2147483647) begin
            res = 32'sh7FFF_FFFF;
        end else if (shifted < -64'sd2147483648) begin
            res = 32'sh8000_0000;
        end else begin
            res = shifted[31:0];
        end
    end

endmodule

`default_nettype wire

// ===== src/hti_div.sv =====
`default_nettype none

module hti_div #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic signed [33:0] num,
    input  wire logic signed [31:0] den,
    output logic                    done,
    output logic signed [31:0]      quot
);

    localparam int MW   = 34 + FRAC_BITS;
    localparam int CNTW = $clog2(MW + 1);

    logic            busy_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [MW-1:0]   work_reg;
    logic [31:0]     rem_reg;
    logic [31:0]     den_reg;
    logic            neg_reg;

    logic [33:0] num_mag;
    logic [31:0] den_mag;
    logic [32:0] rem_sh;
    logic        ge;
    logic [32:0] rem_new;
    logic        big_pos;
    logic        big_neg;

    assign num_mag = num[33] ? (34'd0 - num) : num;
    assign den_mag = den[31] ? (32'd0 - den) : den;
    assign rem_sh  = {rem_reg, work_reg[MW-1]};
    assign ge      = rem_sh >= {1'b0, den_reg};
    assign rem_new = ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
    assign done    = busy_reg && (cnt_reg == '0);

    // Quotient bits shift into the dividend register as its bits move out.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNTW'(MW);
        end else if (done) begin
            busy_reg <= 1'b0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNTW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            work_reg <= {num_mag, FRAC_BITS'(0)};
            rem_reg  <= '0;
            den_reg  <= den_mag;
            neg_reg  <= num[33] ^ den[31];
        end else if (busy_reg && (cnt_reg != '0)) begin
            work_reg <= {work_reg[MW-2:0], ge};
            rem_reg  <= rem_new[31:0];
        end
    end

    assign big_pos = work_reg > MW'(32'h7FFF_FFFF);
    assign big_neg = work_reg > MW'(33'h0_8000_0000);

    always_comb begin
        if (neg_reg) begin
            quot = big_neg ? 32'sh8000_0000 : 32'(MW'(0) - work_reg);
        end else begin
            quot = big_pos ? 32'sh7FFF_FFFF : work_reg[31:0];
        end
    end

endmodule

`default_nettype wire

// ===== src/hermite_table_interpolator.sv =====
// Load request: no result; loads can follow back to back.
// Query request: m_valid rises after the search, with up to 6 probes at 64 knots, and the
// arithmetic at Q16.16; the three divisions dominate.
// No knots, one knot and a zero-width interval take shorter paths without divisions.
// Throughput: one request at a time; the next is taken the cycle after a result is registered.
// Reset clears control state and num_points; table entries are undefined until loaded.
`default_nettype none
`include "hermite_table_interpolator_macros.svh"

module hermite_table_interpolator #(
    parameter int MAX_KNOTS = 64,
    parameter int FRAC_BITS = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [6:0]         cfg_wr_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_command,
    input  wire logic [5:0]         s_entry_index,
    input  wire logic signed [31:0] s_knot_position,
    input  wire logic signed [31:0] s_knot_value,
    input  wire logic signed [31:0] s_knot_slope,
    input  wire logic signed [31:0] s_query_position,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_interp_value,
    output logic signed [31:0]      m_interp_slope,
    output logic [1:0]              m_status
);

    localparam int AW  = $clog2(MAX_KNOTS);
    localparam int NW  = ($clog2(MAX_KNOTS + 1) > 7) ? $clog2(MAX_KNOTS + 1) : 7;
    localparam int IW  = ($clog2(MAX_KNOTS + 1) > 6) ? $clog2(MAX_KNOTS + 1) : 6;

    hti_pkg::state_t state_reg, state_next;
    hti_pkg::step_t  step_reg, step_succ;

    logic [6:0]    num_points_reg;
    logic [NW-1:0] n_eff;
    logic [NW-1:0] lo_reg, hi_reg;
    logic [NW:0]   mid_sum;
    logic [NW-1:0] mid;
    logic [NW-1:0] srch_lo_next, srch_hi_next;
    logic          srch_tie;

    logic signed [31:0] z_reg, x1_reg, y1_reg, s1_reg, x2_reg, y2_reg, s2_reg;
    logic signed [31:0] dx_reg, dy_reg, ya2_reg, ya3_reg, dyn2_reg, dy3_reg;
    logic signed [32:0] d0_reg;
    logic signed [31:0] u_reg, u2_reg, u3_reg, yb2_reg, yb4_reg, t_reg, q1_reg, q2_reg;
    logic signed [34:0] accv_reg, accs_reg;
    logic signed [31:0] res_val_reg, res_slp_reg;
    logic [1:0]         res_status_reg;

    logic               m_valid_reg;
    logic signed [31:0] m_val_reg, m_slp_reg;
    logic [1:0]         m_status_reg;

    logic               accept;
    logic               mem_we;
    logic [AW-1:0]      mem_raddr;
    hti_pkg::knot_t     mem_wdata, mem_rdata;

    logic               mul_load;
    logic signed [31:0] mul_a, mul_b, mul_res;
    logic               div_start, div_done;
    logic signed [33:0] div_num;
    logic signed [31:0] div_quot;
    logic               succ_is_div;
    logic               out_free;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign n_eff = (NW'(num_points_reg) > NW'(MAX_KNOTS)) ? NW'(MAX_KNOTS)
                                                          : NW'(num_points_reg);

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[NW:1];

    // A query equal to the probed knot takes that knot and the next one.
    always_comb begin
        srch_tie     = 1'b0;
        srch_lo_next = lo_reg;
        srch_hi_next = hi_reg;
        if (z_reg < mem_rdata.pos) begin
            srch_hi_next = mid;
        end else if (z_reg > mem_rdata.pos) begin
            srch_lo_next = mid;
        end else begin
            srch_tie     = 1'b1;
            srch_lo_next = mid;
            srch_hi_next = mid + NW'(1);
        end
    end

    assign mem_we    = accept && (s_command == hti_pkg::CMD_LOAD)
                       && (IW'(s_entry_index) < IW'(MAX_KNOTS));
    assign mem_wdata = '{pos: s_knot_position, val: s_knot_value, slope: s_knot_slope};

    hti_knot_mem #(
        .MAX_KNOTS (MAX_KNOTS),
        .AW        (AW)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (AW'(s_entry_index)),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    hti_fxmul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .aclk (aclk),
        .load (mul_load),
        .a    (mul_a),
        .b    (mul_b),
        .res  (mul_res)
    );

    hti_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (dx_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    always_comb begin
        unique case (step_reg)
            hti_pkg::STEP_U:   step_succ = hti_pkg::STEP_U2;
            hti_pkg::STEP_U2:  step_succ = hti_pkg::STEP_U3;
            hti_pkg::STEP_U3:  step_succ = hti_pkg::STEP_YB2;
            hti_pkg::STEP_YB2: step_succ = hti_pkg::STEP_YB4;
            hti_pkg::STEP_YB4: step_succ = hti_pkg::STEP_T;
            hti_pkg::STEP_T:   step_succ = hti_pkg::STEP_VA;
            hti_pkg::STEP_VA:  step_succ = hti_pkg::STEP_VB;
            hti_pkg::STEP_VB:  step_succ = hti_pkg::STEP_VC;
            hti_pkg::STEP_VC:  step_succ = hti_pkg::STEP_Q1;
            hti_pkg::STEP_Q1:  step_succ = hti_pkg::STEP_Q2;
            hti_pkg::STEP_Q2:  step_succ = hti_pkg::STEP_SA;
            hti_pkg::STEP_SA:  step_succ = hti_pkg::STEP_SB;
            hti_pkg::STEP_SB:  step_succ = hti_pkg::STEP_SB;
            default:           step_succ = hti_pkg::STEP_U;
        endcase
    end

    assign succ_is_div = (step_succ == hti_pkg::STEP_Q1) || (step_succ == hti_pkg::STEP_Q2);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            hti_pkg::ST_IDLE: begin
                if (accept && (s_command == hti_pkg::CMD_QUERY)) begin
                    if (n_eff == '0) begin
                        state_next = hti_pkg::ST_RESULT;
                    end else if (n_eff == NW'(1)) begin
                        state_next = hti_pkg::ST_ONE_ADDR;
                    end else if (n_eff > NW'(2)) begin
                        state_next = hti_pkg::ST_SRCH_ADDR;
                    end else begin
                        state_next = hti_pkg::ST_PAIR_LO;
                    end
                end
            end
            hti_pkg::ST_SRCH_ADDR: state_next = hti_pkg::ST_SRCH_CMP;
            hti_pkg::ST_SRCH_CMP: begin
                if (srch_tie || ((srch_hi_next - srch_lo_next) <= NW'(1))) begin
                    state_next = hti_pkg::ST_PAIR_LO;
                end else begin
                    state_next = hti_pkg::ST_SRCH_ADDR;
                end
            end
            hti_pkg::ST_PAIR_LO:  state_next = hti_pkg::ST_PAIR_HI;
            hti_pkg::ST_PAIR_HI:  state_next = hti_pkg::ST_PAIR_END;
            hti_pkg::ST_PAIR_END: state_next = hti_pkg::ST_PREP;
            hti_pkg::ST_PREP: begin
                state_next = (x1_reg == x2_reg) ? hti_pkg::ST_RESULT : hti_pkg::ST_DIV_START;
            end
            hti_pkg::ST_MUL_ISSUE: state_next = hti_pkg::ST_MUL_WB;
            hti_pkg::ST_MUL_WB: begin
                if (step_reg == hti_pkg::STEP_SB) begin
                    state_next = hti_pkg::ST_FINISH;
                end else if (succ_is_div) begin
                    state_next = hti_pkg::ST_DIV_START;
                end else begin
                    state_next = hti_pkg::ST_MUL_ISSUE;
                end
            end
            hti_pkg::ST_DIV_START: state_next = hti_pkg::ST_DIV_WAIT;
            hti_pkg::ST_DIV_WAIT: begin
                if (div_done) begin
                    state_next = succ_is_div ? hti_pkg::ST_DIV_START : hti_pkg::ST_MUL_ISSUE;
                end
            end
            hti_pkg::ST_FINISH:    state_next = hti_pkg::ST_RESULT;
            hti_pkg::ST_ONE_ADDR:  state_next = hti_pkg::ST_ONE_LATCH;
            hti_pkg::ST_ONE_LATCH: state_next = hti_pkg::ST_RESULT;
            hti_pkg::ST_RESULT: begin
                if (out_free) begin
                    state_next = hti_pkg::ST_IDLE;
                end
            end
            default: state_next = hti_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        s_ready   = (state_reg == hti_pkg::ST_IDLE);
        mul_load  = (state_reg == hti_pkg::ST_MUL_ISSUE);
        div_start = (state_reg == hti_pkg::ST_DIV_START);
        unique case (state_reg)
            hti_pkg::ST_SRCH_ADDR: mem_raddr = mid[AW-1:0];
            hti_pkg::ST_PAIR_HI:   mem_raddr = hi_reg[AW-1:0];
            hti_pkg::ST_ONE_ADDR:  mem_raddr = '0;
            default:               mem_raddr = lo_reg[AW-1:0];
        endcase
        case (step_reg)
            hti_pkg::STEP_U2:  begin mul_a = u_reg;  mul_b = u_reg;   end
            hti_pkg::STEP_U3:  begin mul_a = u2_reg; mul_b = u_reg;   end
            hti_pkg::STEP_YB2: begin mul_a = dx_reg; mul_b = ya3_reg; end
            hti_pkg::STEP_YB4: begin mul_a = dx_reg; mul_b = ya2_reg; end
            hti_pkg::STEP_T:   begin mul_a = u_reg;  mul_b = dx_reg;  end
            hti_pkg::STEP_VA:  begin mul_a = t_reg;  mul_b = s1_reg;  end
            hti_pkg::STEP_VB:  begin mul_a = u2_reg; mul_b = yb4_reg; end
            hti_pkg::STEP_VC:  begin mul_a = u3_reg; mul_b = yb2_reg; end
            hti_pkg::STEP_SA:  begin mul_a = q1_reg; mul_b = yb4_reg; end
            default:           begin mul_a = q2_reg; mul_b = yb2_reg; end
        endcase
        case (step_reg)
            hti_pkg::STEP_Q1: div_num = 34'(u_reg) + 34'(u_reg);
            hti_pkg::STEP_Q2: div_num = 34'(u2_reg) + 34'(u2_reg) + 34'(u2_reg);
            default:          div_num = 34'(d0_reg);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= hti_pkg::ST_IDLE;
            num_points_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                num_points_reg <= cfg_wr_data;
            end
            if ((state_reg == hti_pkg::ST_RESULT) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == hti_pkg::ST_RESULT) && out_free) begin
            m_val_reg    <= res_val_reg;
            m_slp_reg    <= res_slp_reg;
            m_status_reg <= res_status_reg;
        end
    end

    // Datapath registers of the sequencer.
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            hti_pkg::ST_IDLE: begin
                z_reg          <= s_query_position;
                lo_reg         <= '0;
                hi_reg         <= n_eff - NW'(1);
                res_val_reg    <= '0;
                res_slp_reg    <= '0;
                res_status_reg <= hti_pkg::STATUS_NO_KNOTS;
            end
            hti_pkg::ST_SRCH_CMP: begin
                lo_reg <= srch_lo_next;
                hi_reg <= srch_hi_next;
            end
            hti_pkg::ST_PAIR_HI: begin
                x1_reg <= mem_rdata.pos;
                y1_reg <= mem_rdata.val;
                s1_reg <= mem_rdata.slope;
            end
            hti_pkg::ST_PAIR_END: begin
                x2_reg <= mem_rdata.pos;
                y2_reg <= mem_rdata.val;
                s2_reg <= mem_rdata.slope;
            end
            hti_pkg::ST_PREP: begin
                dx_reg         <= hti_pkg::sat32(40'(x2_reg) - 40'(x1_reg));
                dy_reg         <= hti_pkg::sat32(40'(y2_reg) - 40'(y1_reg));
                d0_reg         <= 33'(z_reg) - 33'(x1_reg);
                ya2_reg        <= hti_pkg::sat32(40'(s2_reg) + 40'(s1_reg) + 40'(s1_reg));
                ya3_reg        <= hti_pkg::sat32(40'(s2_reg) + 40'(s1_reg));
                step_reg       <= hti_pkg::STEP_U;
                res_val_reg    <= '0;
                res_slp_reg    <= '0;
                res_status_reg <= hti_pkg::STATUS_ZERO_WIDTH;
            end
            hti_pkg::ST_DIV_START: begin
                if (step_reg == hti_pkg::STEP_U) begin
                    dyn2_reg <= hti_pkg::sat32(40'sd0 - (40'(dy_reg) + 40'(dy_reg)));
                    dy3_reg  <= hti_pkg::sat32(40'(dy_reg) + 40'(dy_reg) + 40'(dy_reg));
                end
            end
            hti_pkg::ST_DIV_WAIT: begin
                if (div_done) begin
                    case (step_reg)
                        hti_pkg::STEP_Q1: q1_reg <= div_quot;
                        hti_pkg::STEP_Q2: q2_reg <= div_quot;
                        default:          u_reg  <= div_quot;
                    endcase
                    step_reg <= step_succ;
                end
            end
            hti_pkg::ST_MUL_WB: begin
                case (step_reg)
                    hti_pkg::STEP_U2:  u2_reg <= mul_res;
                    hti_pkg::STEP_U3:  u3_reg <= mul_res;
                    hti_pkg::STEP_YB2: yb2_reg <= hti_pkg::sat32(40'(dyn2_reg) + 40'(mul_res));
                    hti_pkg::STEP_YB4: yb4_reg <= hti_pkg::sat32(40'(dy3_reg) - 40'(mul_res));
                    hti_pkg::STEP_T:   t_reg <= mul_res;
                    hti_pkg::STEP_VA:  accv_reg <= 35'(y1_reg) + 35'(mul_res);
                    hti_pkg::STEP_VB:  accv_reg <= accv_reg + 35'(mul_res);
                    hti_pkg::STEP_VC:  accv_reg <= accv_reg + 35'(mul_res);
                    hti_pkg::STEP_SA:  accs_reg <= 35'(s1_reg) + 35'(mul_res);
                    default:           accs_reg <= accs_reg + 35'(mul_res);
                endcase
                step_reg <= step_succ;
            end
            hti_pkg::ST_FINISH: begin
                res_val_reg    <= hti_pkg::sat32(40'(accv_reg));
                res_slp_reg    <= hti_pkg::sat32(40'(accs_reg));
                res_status_reg <= hti_pkg::STATUS_OK;
            end
            hti_pkg::ST_ONE_LATCH: begin
                res_val_reg    <= mem_rdata.val;
                res_slp_reg    <= '0;
                res_status_reg <= hti_pkg::STATUS_OK;
            end
            default: begin
            end
        endcase
    end

    assign m_valid        = m_valid_reg;
    assign m_interp_value = m_val_reg;
    assign m_interp_slope = m_slp_reg;
    assign m_status       = m_status_reg;

    // A load never produces a result.
    `HTI_ASSERT_NXT(a_load_no_result, aclk, aresetn,
        accept && (s_command == hti_pkg::CMD_LOAD), !$rose(m_valid))
    // Error results carry zero value and slope.
    `HTI_ASSERT_IMP(a_error_zero, aclk, aresetn,
        m_valid && ((m_status == hti_pkg::STATUS_NO_KNOTS) ||
                    (m_status == hti_pkg::STATUS_ZERO_WIDTH)),
        (m_interp_value == 32'sd0) && (m_interp_slope == 32'sd0))
    // The divider only finishes while the sequencer waits for it.
    `HTI_ASSERT_IMP(a_div_done_waiting, aclk, aresetn,
        div_done, state_reg == hti_pkg::ST_DIV_WAIT)

endmodule

`default_nettype wire
